[design/lsu_pkg.sv]
// ============================================================================
// lsu_pkg
// Shared types and constants for the latency statistics unit: input and
// result transactions, the per-run snapshot and the back-end state codes.
// ============================================================================
package lsu_pkg;

    // Run limit and sample width
    localparam int MAX_RUN     = 65535;
    localparam int SAMPLE_BITS = 24;

    // Field and accumulator widths
    localparam int RTT_W  = 24;
    localparam int CNT_W  = 16;
    localparam int S1_W   = 40;
    localparam int S2_W   = 64;
    localparam int SQ_W   = 2 * RTT_W;

    // Largest sample value kept; wider samples clamp to it
    localparam logic [RTT_W-1:0] SAMPLE_MAX = RTT_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // Snapshot queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Input transaction
    typedef struct packed {
        logic [RTT_W-1:0] rtt_ns;
        logic             lost;
        logic             last;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [CNT_W-1:0] sent_count;
        logic [CNT_W-1:0] received_count;
        logic [CNT_W-1:0] lost_count;
        logic [RTT_W-1:0] min_ns;
        logic [RTT_W-1:0] max_ns;
        logic [RTT_W-1:0] mean_ns;
        logic [RTT_W-1:0] stddev_ns;
        logic             overflow;
    } out_item_t;

    // Accumulated state of one finished run
    typedef struct packed {
        logic [CNT_W-1:0] received;
        logic [CNT_W-1:0] lost;
        logic [RTT_W-1:0] min_ns;
        logic [RTT_W-1:0] max_ns;
        logic [S1_W-1:0]  s1;
        logic [S2_W-1:0]  s2;
        logic             overflow;
    } snap_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV1,
        BK_MUL_QQ,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_MUL_QR,
        BK_DIFF,
        BK_DIV2,
        BK_MUL_RR,
        BK_MUL_BN,
        BK_ADJ,
        BK_ROOT,
        BK_DONE
    } back_state_t;

endpackage

[design/lsu_front.sv]
// ============================================================================
// lsu_front
// Accepts one probe outcome per cycle unless a last probe waits on a full queue;
// squares the sample into a stage register and accumulates counts, min, max, sum
// and sum of squares. On a run's last probe it queues a snapshot and clears.
// ============================================================================
module lsu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lsu_pkg::in_item_t in_data,
    output logic             push,
    output lsu_pkg::snap_t   push_data,
    input  logic             queue_full
);

    // Stage register: clamped sample and its square
    logic                          stage_valid_reg;
    logic [lsu_pkg::RTT_W-1:0]     stage_x_reg;
    logic                          stage_lost_reg;
    logic                          stage_last_reg;
    logic [lsu_pkg::SQ_W-1:0]      sq_reg;

    // Run accumulators
    logic [lsu_pkg::CNT_W-1:0]     recv_reg, recv_next;
    logic [lsu_pkg::CNT_W-1:0]     lost_reg, lost_next;
    logic [lsu_pkg::RTT_W-1:0]     min_reg, min_next;
    logic [lsu_pkg::RTT_W-1:0]     max_reg, max_next;
    logic [lsu_pkg::S1_W-1:0]      s1_reg, s1_next;
    logic [lsu_pkg::S2_W-1:0]      s2_reg, s2_next;
    logic                          ovf_reg, ovf_next;

    logic [lsu_pkg::RTT_W-1:0]     x_clamped;
    logic [lsu_pkg::SQ_W-1:0]      sq_next;
    logic                          in_fire;
    logic                          stage_go;
    logic                          run_full;
    logic [lsu_pkg::CNT_W:0]       run_total;

    // Handshake and stage advance; a last probe waits for queue room
    always_comb
    begin
        stage_go  = stage_valid_reg && !(stage_last_reg && queue_full);
        in_ready  = !stage_valid_reg || stage_go;
        in_fire   = in_valid && in_ready;
        x_clamped = (in_data.rtt_ns > lsu_pkg::SAMPLE_MAX) ? lsu_pkg::SAMPLE_MAX
                                                           : in_data.rtt_ns;
        sq_next   = x_clamped * x_clamped;
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_x_reg    <= x_clamped;
            stage_lost_reg <= in_data.lost;
            stage_last_reg <= in_data.last;
            sq_reg         <= sq_next;
        end
    end

    // Accumulate the staged probe
    always_comb
    begin
        run_total = {1'b0, recv_reg} + {1'b0, lost_reg};
        run_full  = run_total >= (lsu_pkg::CNT_W+1)'(lsu_pkg::MAX_RUN);
        recv_next = recv_reg;
        lost_next = lost_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        s1_next   = s1_reg;
        s2_next   = s2_reg;
        ovf_next  = ovf_reg;
        if (stage_go)
        begin
            if (run_full)
            begin
                ovf_next = 1'b1;
            end
            else if (stage_lost_reg)
            begin
                lost_next = lost_reg + 1'b1;
            end
            else
            begin
                if (recv_reg == '0 || stage_x_reg < min_reg)
                begin
                    min_next = stage_x_reg;
                end
                if (recv_reg == '0 || stage_x_reg > max_reg)
                begin
                    max_next = stage_x_reg;
                end
                recv_next = recv_reg + 1'b1;
                s1_next   = s1_reg + lsu_pkg::S1_W'(stage_x_reg);
                s2_next   = s2_reg + lsu_pkg::S2_W'(sq_reg);
            end
        end
        push                = stage_go && stage_last_reg;
        push_data.received  = recv_next;
        push_data.lost      = lost_next;
        push_data.min_ns    = min_next;
        push_data.max_ns    = max_next;
        push_data.s1        = s1_next;
        push_data.s2        = s2_next;
        push_data.overflow  = ovf_next;
    end

    // Accumulator registers; cleared after the run is handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg <= '0;
            lost_reg <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (push)
        begin
            recv_reg <= '0;
            lost_reg <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            recv_reg <= recv_next;
            lost_reg <= lost_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("snapshot pushed into a full queue");

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, recv_reg} + {1'b0, lost_reg}) <= (lsu_pkg::CNT_W+1)'(lsu_pkg::MAX_RUN))
        else $error("run count above limit");

    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (recv_reg == '0 && lost_reg == '0 && !ovf_reg))
        else $error("accumulators not cleared after run end");

endmodule

[design/lsu_queue.sv]
// ============================================================================
// lsu_queue
// Short snapshot queue between the accumulating front end and the
// statistics back end, so each side can stall on its own.
// ============================================================================
module lsu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsu_pkg::snap_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lsu_pkg::snap_t head
);

    lsu_pkg::snap_t                 mem [lsu_pkg::QUEUE_DEPTH];
    logic [lsu_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [lsu_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [lsu_pkg::QUEUE_AW:0]     count_reg;

    function automatic logic [lsu_pkg::QUEUE_AW-1:0] ptr_inc(
        input logic [lsu_pkg::QUEUE_AW-1:0] ptr);
        ptr_inc = (ptr == lsu_pkg::QUEUE_AW'(lsu_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Status and head entry
    always_comb
    begin
        full  = count_reg == (lsu_pkg::QUEUE_AW+1)'(lsu_pkg::QUEUE_DEPTH);
        empty = count_reg == '0;
        head  = mem[rd_ptr_reg];
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Checks
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty snapshot queue");

endmodule

[design/lsu_back.sv]
// ============================================================================
// lsu_back
// Turns a run snapshot into the result: mean by restoring division,
// population variance from the residual sum, root by a bit-pair search.
// One shared 24x24 multiplier, one result register on the output.
// ============================================================================
module lsu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  lsu_pkg::snap_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lsu_pkg::out_item_t out_data
);

    localparam int DIV_W  = lsu_pkg::S2_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    lsu_pkg::back_state_t state_reg, state_next;

    // Snapshot of the run being worked on
    logic [lsu_pkg::CNT_W-1:0]  n_reg;
    logic [lsu_pkg::CNT_W-1:0]  lost_cnt_reg;
    logic [lsu_pkg::RTT_W-1:0]  min_reg;
    logic [lsu_pkg::RTT_W-1:0]  max_reg;
    logic [lsu_pkg::S2_W-1:0]   s2_reg;
    logic                       ovf_reg;
    logic                       none_reg;

    // Divider
    logic [DIV_W-1:0]           num_reg;
    logic [lsu_pkg::CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [lsu_pkg::CNT_W:0]    rem_shift;
    logic                       div_ge;
    logic [lsu_pkg::CNT_W-1:0]  rem_next;

    // Multiplier and intermediate terms
    logic [lsu_pkg::RTT_W-1:0]  mul_a, mul_b;
    logic [lsu_pkg::SQ_W-1:0]   mul_reg;
    logic [lsu_pkg::RTT_W-1:0]  q_reg;
    logic [lsu_pkg::CNT_W-1:0]  r_reg;
    logic [lsu_pkg::RTT_W-1:0]  q2hi_reg;
    logic [lsu_pkg::S2_W-1:0]   acc_reg;
    logic [DIV_W-1:0]           a_reg;
    logic [lsu_pkg::CNT_W-1:0]  b_reg;
    logic [2*lsu_pkg::CNT_W-1:0] rr_reg;
    logic [DIV_W-1:0]           var_val;

    // Square root
    logic [DIV_W-1:0]           v_reg;
    logic [DIV_W-1:0]           res_reg;
    logic [DIV_W-1:0]           bit_reg;
    logic [DIV_W-1:0]           trial;

    // Output register
    logic                       out_valid_reg;
    lsu_pkg::out_item_t         out_reg;
    logic                       load_out;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsu_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            lsu_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = (head.received == '0) ? lsu_pkg::BK_DONE
                                                       : lsu_pkg::BK_DIV1;
                end
            end
            lsu_pkg::BK_DIV1:
            begin
                if (step_reg == '0)
                begin
                    state_next = lsu_pkg::BK_MUL_QQ;
                end
            end
            lsu_pkg::BK_MUL_QQ: state_next = lsu_pkg::BK_MUL_LO;
            lsu_pkg::BK_MUL_LO: state_next = lsu_pkg::BK_MUL_HI;
            lsu_pkg::BK_MUL_HI: state_next = lsu_pkg::BK_MUL_QR;
            lsu_pkg::BK_MUL_QR: state_next = lsu_pkg::BK_DIFF;
            lsu_pkg::BK_DIFF:   state_next = lsu_pkg::BK_DIV2;
            lsu_pkg::BK_DIV2:
            begin
                if (step_reg == '0)
                begin
                    state_next = lsu_pkg::BK_MUL_RR;
                end
            end
            lsu_pkg::BK_MUL_RR: state_next = lsu_pkg::BK_MUL_BN;
            lsu_pkg::BK_MUL_BN: state_next = lsu_pkg::BK_ADJ;
            lsu_pkg::BK_ADJ:    state_next = lsu_pkg::BK_ROOT;
            lsu_pkg::BK_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = lsu_pkg::BK_DONE;
                end
            end
            lsu_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = lsu_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lsu_pkg::BK_IDLE;
            end
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            lsu_pkg::BK_MUL_QQ:
            begin
                mul_a = q_reg;
                mul_b = q_reg;
            end
            lsu_pkg::BK_MUL_LO:
            begin
                mul_a = mul_reg[lsu_pkg::RTT_W-1:0];
                mul_b = lsu_pkg::RTT_W'(n_reg);
            end
            lsu_pkg::BK_MUL_HI:
            begin
                mul_a = q2hi_reg;
                mul_b = lsu_pkg::RTT_W'(n_reg);
            end
            lsu_pkg::BK_MUL_QR:
            begin
                mul_a = q_reg;
                mul_b = lsu_pkg::RTT_W'(r_reg);
            end
            lsu_pkg::BK_MUL_RR:
            begin
                mul_a = lsu_pkg::RTT_W'(r_reg);
                mul_b = lsu_pkg::RTT_W'(r_reg);
            end
            lsu_pkg::BK_MUL_BN:
            begin
                mul_a = lsu_pkg::RTT_W'(b_reg);
                mul_b = lsu_pkg::RTT_W'(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // One restoring-division step, one root trial, variance correction
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[DIV_W-1]};
        div_ge    = rem_shift >= {1'b0, n_reg};
        rem_next  = div_ge ? lsu_pkg::CNT_W'(rem_shift - {1'b0, n_reg})
                           : lsu_pkg::CNT_W'(rem_shift);
        trial     = res_reg + bit_reg;
        // floor(d/n) overshoots by one when the remainder term is short
        if (mul_reg[2*lsu_pkg::CNT_W-1:0] < rr_reg)
        begin
            var_val = (a_reg != '0) ? a_reg - 1'b1 : '0;
        end
        else
        begin
            var_val = a_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lsu_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    n_reg        <= head.received;
                    lost_cnt_reg <= head.lost;
                    min_reg      <= head.min_ns;
                    max_reg      <= head.max_ns;
                    s2_reg       <= head.s2;
                    ovf_reg      <= head.overflow;
                    none_reg     <= head.received == '0;
                    // sum left-aligned so only its own bits are stepped
                    num_reg      <= {head.s1, {(DIV_W - lsu_pkg::S1_W){1'b0}}};
                    rem_reg      <= '0;
                    step_reg     <= STEP_W'(lsu_pkg::S1_W);
                end
            end
            lsu_pkg::BK_DIV1:
            begin
                if (step_reg != '0)
                begin
                    num_reg  <= {num_reg[DIV_W-2:0], div_ge};
                    rem_reg  <= rem_next;
                    step_reg <= step_reg - 1'b1;
                end
                else
                begin
                    q_reg <= num_reg[lsu_pkg::RTT_W-1:0];
                    r_reg <= rem_reg;
                end
            end
            lsu_pkg::BK_MUL_LO:
            begin
                q2hi_reg <= mul_reg[lsu_pkg::SQ_W-1:lsu_pkg::RTT_W];
            end
            lsu_pkg::BK_MUL_HI:
            begin
                acc_reg <= lsu_pkg::S2_W'(mul_reg);
            end
            lsu_pkg::BK_MUL_QR:
            begin
                acc_reg <= acc_reg + (lsu_pkg::S2_W'(mul_reg) << lsu_pkg::RTT_W);
            end
            lsu_pkg::BK_DIFF:
            begin
                // residual sum of squares about the mean
                num_reg  <= s2_reg - acc_reg - (lsu_pkg::S2_W'(mul_reg) << 1);
                rem_reg  <= '0;
                step_reg <= STEP_W'(DIV_W);
            end
            lsu_pkg::BK_DIV2:
            begin
                if (step_reg != '0)
                begin
                    num_reg  <= {num_reg[DIV_W-2:0], div_ge};
                    rem_reg  <= rem_next;
                    step_reg <= step_reg - 1'b1;
                end
                else
                begin
                    a_reg <= num_reg;
                    b_reg <= rem_reg;
                end
            end
            lsu_pkg::BK_MUL_BN:
            begin
                rr_reg <= mul_reg[2*lsu_pkg::CNT_W-1:0];
            end
            lsu_pkg::BK_ADJ:
            begin
                v_reg   <= var_val;
                res_reg <= '0;
                bit_reg <= DIV_W'(1) << (DIV_W - 2);
            end
            lsu_pkg::BK_ROOT:
            begin
                if (bit_reg != '0)
                begin
                    if (v_reg >= trial)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.sent_count     <= n_reg + lost_cnt_reg;
            out_reg.received_count <= n_reg;
            out_reg.lost_count     <= lost_cnt_reg;
            out_reg.min_ns         <= none_reg ? '0 : min_reg;
            out_reg.max_ns         <= none_reg ? '0 : max_reg;
            out_reg.mean_ns        <= none_reg ? '0 : q_reg;
            out_reg.stddev_ns      <= none_reg ? '0 : res_reg[lsu_pkg::RTT_W-1:0];
            out_reg.overflow       <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_remainders_small: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsu_pkg::BK_MUL_RR) |-> (b_reg < n_reg && r_reg < n_reg))
        else $error("division remainder not below received count");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lsu_pkg::BK_DONE))
        else $error("result raised outside the final state");

endmodule

[design/latency_statistics_unit.sv]
// ============================================================================
// latency_statistics_unit
// Probe latency statistics: counts, min, max, floor mean and floor
// population standard deviation per run, one result per last-marked probe.
// ============================================================================
// Throughput: one probe per cycle; the front accumulator never stalls
//   except on a last probe while the two-entry snapshot queue is full.
// Back end: one run at a time, through a 40-step mean divide, a 64-step
//   variance divide and a 32-step root before the result register.
// Reset: asynchronous, active low; clears accumulators, queue and result valid.
module latency_statistics_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsu_pkg::out_item_t out_data
);

    logic           push;
    lsu_pkg::snap_t push_data;
    logic           queue_full;
    logic           pop;
    logic           queue_empty;
    lsu_pkg::snap_t head;

    // Accumulating front end
    lsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Run snapshots waiting for the back end
    lsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head      (head)
    );

    // Statistics back end
    lsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
